@@ rtl/hfb_pkg.sv @@
package hfb_pkg;

  localparam int unsigned FRAME_BUFFER_BYTES = 1024;
  localparam int unsigned CNT_W = $clog2(FRAME_BUFFER_BYTES - 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(FRAME_BUFFER_BYTES - 2);

  localparam logic [7:0]  ESC_BYTE   = 8'h7D;
  localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
  localparam logic [7:0]  ESC_XOR    = 8'h20;
  localparam logic [15:0] CRC_POLY   = 16'h8408;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_XOROUT = 16'hFFFF;

  // Byte positions walked by the escaper for one item
  localparam logic [1:0] POS_DATA   = 2'd0;
  localparam logic [1:0] POS_CRC_LO = 2'd1;
  localparam logic [1:0] POS_CRC_HI = 2'd2;
  localparam logic [1:0] POS_FLAG   = 2'd3;

  typedef struct packed {
    logic        err;      // length error, single zero byte
    logic        closing;  // last payload byte: append CRC and flag
    logic [7:0]  data;
    logic [15:0] fcs;      // final CRC, already inverted
  } hfb_job_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

endpackage

@@ rtl/hfb_frame_ctl.sv @@
module hfb_frame_ctl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_data_byte,
  input  logic             in_last_byte,
  input  logic             job_take,
  output logic             job_valid,
  output hfb_pkg::hfb_job_t job
);
  import hfb_pkg::*;

  logic [15:0]      crc_r, crc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             discard_r, discard_nxt;
  logic             pend_v_r, pend_v_nxt;
  hfb_job_t         pend_r, pend_nxt;
  logic             accept;
  logic             new_job;
  logic [15:0]      crc_upd;

  assign in_stall  = pend_v_r && !job_take;
  assign accept    = in_valid && !in_stall;
  assign crc_upd   = crc_byte(crc_r, in_data_byte);
  assign job_valid = pend_v_r;
  assign job       = pend_r;

  always_comb begin
    crc_nxt     = crc_r;
    cnt_nxt     = cnt_r;
    discard_nxt = discard_r;
    new_job     = 1'b0;
    pend_nxt    = pend_r;
    if (accept) begin
      if (discard_r) begin
        // drop silently until the end of the oversized frame
        if (in_last_byte) begin
          discard_nxt = 1'b0;
        end
      end else if (cnt_r >= CNT_LIMIT) begin
        new_job          = 1'b1;
        pend_nxt.err     = 1'b1;
        pend_nxt.closing = 1'b0;
        pend_nxt.data    = 8'h00;
        pend_nxt.fcs     = 16'h0000;
        crc_nxt          = CRC_INIT;
        cnt_nxt          = '0;
        discard_nxt      = !in_last_byte;
      end else begin
        new_job          = 1'b1;
        pend_nxt.err     = 1'b0;
        pend_nxt.closing = in_last_byte;
        pend_nxt.data    = in_data_byte;
        pend_nxt.fcs     = crc_upd ^ CRC_XOROUT;
        if (in_last_byte) begin
          crc_nxt = CRC_INIT;
          cnt_nxt = '0;
        end else begin
          crc_nxt = crc_upd;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    end
    if (new_job) begin
      pend_v_nxt = 1'b1;
    end else if (job_take) begin
      pend_v_nxt = 1'b0;
    end else begin
      pend_v_nxt = pend_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r     <= CRC_INIT;
      cnt_r     <= '0;
      discard_r <= 1'b0;
      pend_v_r  <= 1'b0;
    end else begin
      crc_r     <= crc_nxt;
      cnt_r     <= cnt_nxt;
      discard_r <= discard_nxt;
      pend_v_r  <= pend_v_nxt;
    end
    pend_r <= pend_nxt;
  end

`ifndef SYNTH
  a_discard_clean: assert property (@(posedge clk) disable iff (!rst_n)
    discard_r |-> (cnt_r == '0) && (crc_r == CRC_INIT))
    else $error("frame state not cleared while discarding");

  a_discard_ends: assert property (@(posedge clk) disable iff (!rst_n)
    accept && discard_r && in_last_byte |=> !discard_r && !pend_v_r)
    else $error("discard not ended by last byte");
`endif

endmodule

@@ rtl/hfb_escaper.sv @@
module hfb_escaper (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  hfb_pkg::hfb_job_t job,
  output logic              job_take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_wire_byte,
  output logic              out_run_last,
  output logic              out_frame_end,
  output logic              out_length_error
);
  import hfb_pkg::*;

  hfb_job_t   cur_r, cur_nxt;
  logic       cur_v_r, cur_v_nxt;
  logic [1:0] pos_r, pos_nxt;
  logic       esc_r, esc_nxt;
  logic       out_v_r, out_v_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       end_r, end_nxt;
  logic       err_r, err_nxt;
  logic       adv;
  logic       done;
  logic [7:0] sel;

  assign adv = !out_v_r || !out_stall;

  always_comb begin
    case (pos_r)
      POS_DATA:   sel = cur_r.data;
      POS_CRC_LO: sel = cur_r.fcs[7:0];
      POS_CRC_HI: sel = cur_r.fcs[15:8];
      default:    sel = FLAG_BYTE;
    endcase
  end

  always_comb begin
    out_v_nxt = out_v_r && out_stall;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    end_nxt   = end_r;
    err_nxt   = err_r;
    pos_nxt   = pos_r;
    esc_nxt   = esc_r;
    done      = 1'b0;
    if (adv && cur_v_r) begin
      out_v_nxt = 1'b1;
      last_nxt  = 1'b0;
      end_nxt   = 1'b0;
      err_nxt   = 1'b0;
      if (cur_r.err) begin
        byte_nxt = 8'h00;
        err_nxt  = 1'b1;
        last_nxt = 1'b1;
        done     = 1'b1;
      end else if (pos_r == POS_FLAG) begin
        byte_nxt = FLAG_BYTE;
        end_nxt  = 1'b1;
        last_nxt = 1'b1;
        done     = 1'b1;
      end else if (needs_escape(sel) && !esc_r) begin
        byte_nxt = ESC_BYTE;
        esc_nxt  = 1'b1;
      end else begin
        byte_nxt = esc_r ? (sel ^ ESC_XOR) : sel;
        esc_nxt  = 1'b0;
        if (pos_r == POS_DATA && !cur_r.closing) begin
          last_nxt = 1'b1;
          done     = 1'b1;
        end else begin
          pos_nxt = pos_r + 2'd1;
        end
      end
    end
    // load the next item as soon as the current one has gone out
    job_take = !cur_v_r || done;
    cur_nxt  = cur_r;
    if (job_take) begin
      cur_v_nxt = job_valid;
      cur_nxt   = job;
      pos_nxt   = POS_DATA;
      esc_nxt   = 1'b0;
    end else begin
      cur_v_nxt = cur_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      pos_r   <= POS_DATA;
      esc_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      pos_r   <= pos_nxt;
      esc_r   <= esc_nxt;
      out_v_r <= out_v_nxt;
    end
    cur_r  <= cur_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    end_r  <= end_nxt;
    err_r  <= err_nxt;
  end

  assign out_valid        = out_v_r;
  assign out_wire_byte    = byte_r;
  assign out_run_last     = last_r;
  assign out_frame_end    = end_r;
  assign out_length_error = err_r;

`ifndef SYNTH
  a_flag_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && end_r |-> (byte_r == FLAG_BYTE) && last_r && !err_r)
    else $error("closing flag result malformed");

  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && err_r |-> (byte_r == 8'h00) && last_r && !end_r)
    else $error("length error result malformed");

  a_esc_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (byte_r == ESC_BYTE) && !out_stall |=> out_v_r && (byte_r != ESC_BYTE))
    else $error("escape prefix not followed by its byte");

  a_esc_pending: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> cur_v_r && !cur_r.err && (pos_r != POS_FLAG))
    else $error("escape pending without a byte to send");
`endif

endmodule

@@ rtl/hdlc_frame_builder_core.sv @@
// HDLC frame builder with CRC-16/X-25. Feed the payload bytes of a frame
// (command byte first) with in_last_byte on the final one; each byte leaves
// escaped (0x7E/0x7D become 0x7D, byte ^ 0x20), and the last is followed by
// the escaped CRC low and high bytes and an unescaped 0x7E flag. A frame of
// more than FRAME_BUFFER_BYTES - 2 payload bytes gives one zero byte with
// out_length_error set and the rest of it, up to its last byte, is dropped.
// Rate: the output port carries one wire byte per cycle while out_stall is
// low; a payload byte yields one or two wire bytes, and a last byte up to
// seven; one further item is held while the current one is sent, so input
// and output run concurrently.
module hdlc_frame_builder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_wire_byte,
  output logic       out_run_last,
  output logic       out_frame_end,
  output logic       out_length_error
);
  import hfb_pkg::*;

  hfb_job_t job;
  logic     job_valid;
  logic     job_take;

  hfb_frame_ctl u_frame_ctl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .job_take     (job_take),
    .job_valid    (job_valid),
    .job          (job)
  );

  hfb_escaper u_escaper (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_valid        (job_valid),
    .job              (job),
    .job_take         (job_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_wire_byte    (out_wire_byte),
    .out_run_last     (out_run_last),
    .out_frame_end    (out_frame_end),
    .out_length_error (out_length_error)
  );

endmodule
